[src/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge package
// Shared widths, default sizes and the queued item type.
// ----------------------------------------------------------------------------
`default_nettype none

package kwm_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned LIST_NUM_W     = 2;
  localparam int unsigned NUM_LISTS_DEF  = 4;
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic [LIST_NUM_W-1:0]    list_number;
    logic signed [DATA_W-1:0] element;
    logic                     final_element;
    logic                     in_range;
  } kwm_item_t;

endpackage

`default_nettype wire

[src/kwm_if.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge channels
// Valid/ready channels for input items and merged result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwm_in_if;
  logic                             valid;
  logic                             ready;
  logic [kwm_pkg::LIST_NUM_W-1:0]   list_number;
  logic signed [kwm_pkg::DATA_W-1:0] element;
  logic                             final_element;

  modport source (output valid, output list_number, output element, output final_element,
                  input ready);
  modport sink (input valid, input list_number, input element, input final_element,
                output ready);
endinterface

interface kwm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [kwm_pkg::DATA_W-1:0] merged_value;
  logic [kwm_pkg::LIST_NUM_W-1:0]   source_list;
  logic                             end_of_run;
  logic                             dropped_seen;

  modport source (output valid, output merged_value, output source_list, output end_of_run,
                  output dropped_seen, input ready);
  modport sink (input valid, input merged_value, input source_list, input end_of_run,
                input dropped_seen, output ready);
endinterface

`default_nettype wire

[src/kwm_front.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge front end
// Registers each input item and marks whether its list number is in range.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_front #(
  parameter int unsigned NUM_LISTS = kwm_pkg::NUM_LISTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  kwm_in_if.sink             in_i,
  output kwm_pkg::kwm_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);
  import kwm_pkg::*;

  kwm_item_t item_q;
  logic      valid_q;
  logic      accept;

  assign in_i.ready   = !valid_q || item_ready_i;
  assign accept       = in_i.valid && in_i.ready;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      item_q  <= '0;
    end else begin
      if (accept) begin
        valid_q              <= 1'b1;
        item_q.list_number   <= in_i.list_number;
        item_q.element       <= in_i.element;
        item_q.final_element <= in_i.final_element;
        item_q.in_range      <= int'(in_i.list_number) < int'(NUM_LISTS);
      end else if (item_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/kwm_fifo.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge item queue
// A short first-in first-out queue between the front end and the merge engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kwm_pkg::kwm_item_t push_item_i,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  output kwm_pkg::kwm_item_t pop_item_o,
  output logic               pop_valid_o,
  input  logic               pop_ready_i
);
  import kwm_pkg::*;

  localparam int unsigned QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QUEUE_DEPTH + 1);

  kwm_item_t           store_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q;
  logic [QUEUE_AW-1:0] rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                push;
  logic                pop;

  assign push_ready_o = count_q != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[src/kwm_back.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge engine
// Stores elements per list and, on the final item, merges all lists in order.
// ----------------------------------------------------------------------------
`default_nettype none

module kwm_back #(
  parameter int unsigned NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kwm_pkg::kwm_item_t item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  kwm_out_if.source          out_o
);
  import kwm_pkg::*;

  localparam int unsigned LANE_W  = $clog2(NUM_LISTS);
  localparam int unsigned LCNT_W  = $clog2(NUM_LISTS + 1);
  localparam int unsigned CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned ENTRIES = NUM_LISTS * LIST_DEPTH;
  localparam int unsigned ADDR_W  = $clog2(ENTRIES);
  localparam int unsigned TOT_W   = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                   state_q;
  logic [DATA_W-1:0]        mem [ENTRIES];
  logic [DATA_W-1:0]        rd_data_q;
  logic [CNT_W-1:0]         fill_q [NUM_LISTS];
  logic [CNT_W-1:0]         head_q [NUM_LISTS];
  logic                     drop_q;
  logic [TOT_W-1:0]         total_q;
  logic [TOT_W-1:0]         emitted_q;
  logic [LCNT_W-1:0]        lane_q;
  logic                     rd_vld_q;
  logic [LANE_W-1:0]        rd_lane_q;
  logic                     found_q;
  logic [LANE_W-1:0]        best_q;
  logic signed [DATA_W-1:0] best_val_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] merged_q;
  logic [LIST_NUM_W-1:0]    source_q;
  logic                     end_q;
  logic                     dropped_q;

  logic [LANE_W-1:0] ld_lane;
  logic              ld_store;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [LANE_W-1:0] scan_lane;
  logic              scan_issue;
  logic              scan_live;
  logic              mem_re;
  logic [ADDR_W-1:0] rd_addr;
  logic              emit_ok;
  logic              last_out;

  assign item_ready_o = state_q == ST_LOAD;
  assign ld_lane      = LANE_W'(item_i.list_number);
  assign ld_store     = item_i.in_range && (fill_q[ld_lane] < CNT_W'(LIST_DEPTH));
  assign mem_we       = item_valid_i && item_ready_o && ld_store;
  assign wr_addr      = ADDR_W'(ld_lane) * ADDR_W'(LIST_DEPTH) + ADDR_W'(fill_q[ld_lane]);

  assign scan_lane  = lane_q[LANE_W-1:0];
  assign scan_issue = (state_q == ST_SCAN) && (lane_q < LCNT_W'(NUM_LISTS));
  assign scan_live  = head_q[scan_lane] < fill_q[scan_lane];
  assign mem_re     = scan_issue && scan_live;
  assign rd_addr    = ADDR_W'(scan_lane) * ADDR_W'(LIST_DEPTH) + ADDR_W'(head_q[scan_lane]);

  assign emit_ok  = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign last_out = TOT_W'(emitted_q + 1'b1) == total_q;

  assign out_o.valid        = out_valid_q;
  assign out_o.merged_value = merged_q;
  assign out_o.source_list  = source_q;
  assign out_o.end_of_run   = end_q;
  assign out_o.dropped_seen = dropped_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= item_i.element;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_q[i] <= '0;
        head_q[i] <= '0;
      end
      drop_q      <= 1'b0;
      total_q     <= '0;
      emitted_q   <= '0;
      lane_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_lane_q   <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_val_q  <= '0;
      out_valid_q <= 1'b0;
      merged_q    <= '0;
      source_q    <= '0;
      end_q       <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_LOAD: begin
          if (item_valid_i) begin
            if (ld_store) begin
              fill_q[ld_lane] <= fill_q[ld_lane] + 1'b1;
              total_q         <= total_q + 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
            if (item_i.final_element) begin
              if ((total_q == '0) && !ld_store) begin
                drop_q <= 1'b0;
              end else begin
                emitted_q <= '0;
                lane_q    <= '0;
                found_q   <= 1'b0;
                rd_vld_q  <= 1'b0;
                state_q   <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            lane_q <= lane_q + 1'b1;
          end
          rd_vld_q  <= mem_re;
          rd_lane_q <= scan_lane;
          if (rd_vld_q && (!found_q || ($signed(rd_data_q) < best_val_q))) begin
            found_q    <= 1'b1;
            best_q     <= rd_lane_q;
            best_val_q <= $signed(rd_data_q);
          end
          if (!scan_issue) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_q    <= 1'b1;
            merged_q       <= best_val_q;
            source_q       <= LIST_NUM_W'(best_q);
            end_q          <= last_out;
            dropped_q      <= drop_q;
            head_q[best_q] <= head_q[best_q] + 1'b1;
            emitted_q      <= emitted_q + 1'b1;
            if (last_out) begin
              for (int i = 0; i < NUM_LISTS; i++) begin
                fill_q[i] <= '0;
                head_q[i] <= '0;
              end
              drop_q  <= 1'b0;
              total_q <= '0;
              state_q <= ST_LOAD;
            end else begin
              lane_q  <= '0;
              found_q <= 1'b0;
              state_q <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/k_way_sorted_merge_top.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge top level
// Loads tagged elements into per-list stores and merges them into one run.
// ----------------------------------------------------------------------------
// Each input item is stored when it reaches the merge engine, so while no
// merge runs a set loads at one element per cycle through a front register and
// a two-entry queue. An item marked final starts the merge; for each result the
// engine reads the current head of each list through the single read port of
// the element store, one list per cycle, keeps the smallest (lowest list number
// on ties), then hands it to the output register. Elements sent to a full list
// or to a list number at or above NUM_LISTS are dropped and reported on every
// result of that run. A final item with no stored elements produces no
// results. No new items are taken while a merge runs; the front register and
// queue still absorb up to three items.
`default_nettype none

module k_way_sorted_merge_top #(
  parameter int unsigned NUM_LISTS  = kwm_pkg::NUM_LISTS_DEF,
  parameter int unsigned LIST_DEPTH = kwm_pkg::LIST_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kwm_in_if.sink    in_i,
  kwm_out_if.source out_o
);
  import kwm_pkg::*;

  kwm_item_t front_item;
  logic      front_valid;
  logic      front_ready;
  kwm_item_t queue_item;
  logic      queue_valid;
  logic      queue_ready;

  kwm_front #(
    .NUM_LISTS (NUM_LISTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  kwm_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (queue_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready)
  );

  kwm_back #(
    .NUM_LISTS  (NUM_LISTS),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (queue_item),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

[verif/k_way_sorted_merge_top_tb.sv]
// ----------------------------------------------------------------------------
// K-way sorted merge testbench
// Sends tagged data sets through the input channel and checks every merged
// item against a local merge of the same lists. The sender idles in bursts and
// the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------

module k_way_sorted_merge_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  localparam int NL          = NUM_LISTS_DEF;
  localparam int LD          = LIST_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 236;

  typedef struct {
    logic [LIST_NUM_W-1:0]    list_number;
    logic signed [DATA_W-1:0] element;
    logic                     final_element;
    bit                       wait_for_drain;
  } load_item_t;

  typedef struct {
    logic signed [DATA_W-1:0] merged_value;
    logic [LIST_NUM_W-1:0]    source_list;
    logic                     end_of_run;
    logic                     dropped_seen;
  } merged_item_t;

  typedef enum int {
    SET_SORTED,
    SET_UNSORTED,
    SET_ONE_LIST
  } set_kind_e;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_LONG_STALL
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  kwm_in_if  in_bus ();
  kwm_out_if out_bus ();

  k_way_sorted_merge_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  load_item_t   load_q[$];
  merged_item_t merged_run_q[$];

  logic signed [DATA_W-1:0] list_store [NL][LD];
  int                       list_count [NL];
  bit                       overflowed;

  load_item_t cur_item;
  int         burst_left;
  int         gap_left;
  int         items_sent;

  rx_mode_e rx_mode;
  int       rx_mode_left;
  int       rx_hold;

  int err_cnt;
  int results_checked;
  int runs_seen;
  int drop_runs;
  int cycle_cnt;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic store_and_merge(input load_item_t it);
    int           total;
    int           head [NL];
    int           pick;
    bit           found;
    merged_item_t r;
    if (it.list_number < NL && list_count[it.list_number] < LD) begin
      list_store[it.list_number][list_count[it.list_number]] = it.element;
      list_count[it.list_number]++;
    end else begin
      overflowed = 1'b1;
    end
    if (it.final_element) begin
      total = 0;
      for (int l = 0; l < NL; l++) begin
        head[l] = 0;
        total += list_count[l];
      end
      for (int k = 0; k < total; k++) begin
        found = 1'b0;
        pick  = 0;
        for (int l = 0; l < NL; l++) begin
          if (head[l] < list_count[l] &&
              (!found || list_store[l][head[l]] < list_store[pick][head[pick]])) begin
            found = 1'b1;
            pick  = l;
          end
        end
        r.merged_value = list_store[pick][head[pick]];
        r.source_list  = LIST_NUM_W'(pick);
        r.end_of_run   = (k == total - 1);
        r.dropped_seen = overflowed;
        merged_run_q   = {merged_run_q, r};
        head[pick]++;
      end
      for (int l = 0; l < NL; l++) list_count[l] = 0;
      overflowed = 1'b0;
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1: return $signed($urandom_range(0, 16)) - 8;
      2: return $urandom_range(0, 1000);
      3: return -$signed($urandom_range(0, 1000));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_item(input int lst, input logic signed [DATA_W-1:0] val,
                           input bit fin, input bit hold);
    load_item_t it;
    it.list_number    = LIST_NUM_W'(lst);
    it.element        = val;
    it.final_element  = fin;
    it.wait_for_drain = hold;
    load_q            = {load_q, it};
  endtask

  task automatic queue_data_set(input int n, input set_kind_e kind, input bit hold);
    int                       lst [$];
    int                       vals [NL][$];
    int                       hot;
    int                       l;
    logic signed [DATA_W-1:0] v;
    hot = $urandom_range(0, NL - 1);
    for (int k = 0; k < n; k++) begin
      if (kind == SET_ONE_LIST && $urandom_range(0, 4) != 0) l = hot;
      else l = $urandom_range(0, NL - 1);
      lst     = {lst, l};
      vals[l] = {vals[l], int'(pick_element())};
    end
    if (kind != SET_UNSORTED) begin
      for (int j = 0; j < NL; j++) vals[j].sort();
    end
    for (int k = 0; k < n; k++) begin
      v = vals[lst[k]].pop_front();
      push_item(lst[k], v, k == n - 1, hold && k == 0);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic drive_valid;
    if (!rst_ni) begin
      in_bus.valid         <= 1'b0;
      in_bus.list_number   <= '0;
      in_bus.element       <= '0;
      in_bus.final_element <= 1'b0;
      burst_left           = 0;
      gap_left             = 0;
      items_sent           = 0;
      overflowed           = 1'b0;
      for (int l = 0; l < NL; l++) list_count[l] = 0;
    end else begin
      drive_valid = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        store_and_merge(cur_item);
        items_sent++;
        drive_valid = 1'b0;
      end
      if (!drive_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (load_q.size() != 0 &&
                     !(load_q[0].wait_for_drain && merged_run_q.size() != 0)) begin
          cur_item             = load_q.pop_front();
          in_bus.list_number   <= cur_item.list_number;
          in_bus.element       <= cur_item.element;
          in_bus.final_element <= cur_item.final_element;
          drive_valid          = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      in_bus.valid <= drive_valid;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    merged_item_t want;
    logic         rdy;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      rx_mode       = RX_ALWAYS;
      rx_mode_left  = 0;
      rx_hold       = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_checked++;
        if (out_bus.end_of_run === 1'b1) runs_seen++;
        if (out_bus.end_of_run === 1'b1 && out_bus.dropped_seen === 1'b1) drop_runs++;
        if (merged_run_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected merged item value %0d list %0d", $time,
                   out_bus.merged_value, out_bus.source_list);
        end else begin
          want = merged_run_q.pop_front();
          if (out_bus.merged_value !== want.merged_value) begin
            err_cnt++;
            $display("%0t: merged_value expected %0d actual %0d", $time,
                     want.merged_value, out_bus.merged_value);
          end
          if (out_bus.source_list !== want.source_list) begin
            err_cnt++;
            $display("%0t: source_list expected %0d actual %0d", $time,
                     want.source_list, out_bus.source_list);
          end
          if (out_bus.end_of_run !== want.end_of_run) begin
            err_cnt++;
            $display("%0t: end_of_run expected %0b actual %0b", $time,
                     want.end_of_run, out_bus.end_of_run);
          end
          if (out_bus.dropped_seen !== want.dropped_seen) begin
            err_cnt++;
            $display("%0t: dropped_seen expected %0b actual %0b", $time,
                     want.dropped_seen, out_bus.dropped_seen);
          end
        end
      end
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(50, 300);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_ALWAYS: rdy = 1'b1;
        RX_RANDOM: rdy = ($urandom_range(0, 9) < 7);
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 25);
          end
        end
      endcase
      out_bus.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d merged items still expected", $time,
               cycle_cnt, merged_run_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int        n;
    int        pick;
    int        queued;
    set_kind_e kind;
    rst_ni               = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.list_number   = '0;
    in_bus.element       = '0;
    in_bus.final_element = 1'b0;
    out_bus.ready        = 1'b0;
    err_cnt              = 0;
    results_checked      = 0;
    runs_seen            = 0;
    drop_runs            = 0;
    cycle_cnt            = 0;

    // Single-element runs at the two extremes of the element range.
    push_item(0, 32'sh8000_0000, 1'b1, 1'b0);
    push_item(3, 32'sh7fff_ffff, 1'b1, 1'b0);
    // Equal values of 5 on every list, with a -1 ahead on list 2; the lowest list number must win each tie.
    push_item(3, 5, 1'b0, 1'b0);
    push_item(1, 5, 1'b0, 1'b0);
    push_item(0, 5, 1'b0, 1'b0);
    push_item(2, -1, 1'b0, 1'b0);
    push_item(2, 5, 1'b1, 1'b0);
    // One list filled past its depth; the final item is dropped yet still starts the merge.
    for (int k = 0; k < LD + 1; k++) begin
      push_item(2, k * 1000 - 7000, k == LD, k == 0);
    end

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        kind = SET_SORTED;
        n    = $urandom_range(1, 12);
      end else if (pick < 82) begin
        kind = SET_UNSORTED;
        n    = $urandom_range(1, 12);
      end else if (pick < 92) begin
        kind = SET_SORTED;
        n    = $urandom_range(13, 30);
      end else begin
        kind = SET_ONE_LIST;
        n    = $urandom_range(18, 70);
      end
      if (n > RANDOM_ITEMS - queued) n = RANDOM_ITEMS - queued;
      queue_data_set(n, kind, $urandom_range(0, 9) == 0);
      queued += n;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (load_q.size() != 0 || in_bus.valid || merged_run_q.size() != 0);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d items and checked %0d merged items over %0d runs,", items_sent,
             results_checked, runs_seen);
    $display("%0d of those runs reported dropped elements.", drop_runs);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
src/kwm_pkg.sv
src/kwm_if.sv
src/kwm_front.sv
src/kwm_fifo.sv
src/kwm_back.sv
src/k_way_sorted_merge_top.sv
verif/k_way_sorted_merge_top_tb.sv
